// ===== hw/rtl/kt_pkg.sv =====
// ----------------------------------------------------------------------------
// kt_pkg: shared types for the keyed table
// Request and status codes, control FSM states and the per-cell command.
// ----------------------------------------------------------------------------
package kt_pkg;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_UPDATE = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_DUP      = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_NEGQ     = 3'd5,
        ST_BADPOS   = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_MATCH  = 4'b0010,
        S_REDUCE = 4'b0100,
        S_APPLY  = 4'b1000
    } state_t;

    // command broadcast to every cell
    typedef struct packed {
        logic compare;
        logic ins;
        logic upd;
        logic shift;
    } cell_cmd_t;

    localparam int KEY_W = 32;
    localparam int QTY_W = 31;

endpackage

// ===== hw/rtl/kt_cell.sv =====
// ----------------------------------------------------------------------------
// kt_cell: one table slot
// Holds one key/quantity pair, compares against the request key and loads
// from its upper neighbor when the table compacts after a removal.
// ----------------------------------------------------------------------------
module kt_cell #(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 6,
    parameter int CNT_W    = 7
) (
    input  logic                       clk,
    input  kt_pkg::cell_cmd_t          cmd,
    input  logic [kt_pkg::KEY_W-1:0]   req_key,
    input  logic [kt_pkg::QTY_W-1:0]   req_qty,
    input  logic [CNT_W-1:0]           count,
    input  logic [IDX_W-1:0]           hit_idx,
    input  logic [kt_pkg::KEY_W-1:0]   nb_key,
    input  logic [kt_pkg::QTY_W-1:0]   nb_qty,
    output logic [kt_pkg::KEY_W-1:0]   key_reg,
    output logic [kt_pkg::QTY_W-1:0]   qty_reg,
    output logic                       match_reg
);

    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic live;

    assign live = (MY_CNT < count);

    always_ff @(posedge clk)
    begin
        if (cmd.compare)
        begin
            match_reg <= live && (key_reg == req_key);
        end

        if (cmd.ins && (MY_CNT == count))
        begin
            key_reg <= req_key;
            qty_reg <= req_qty;
        end
        else if (cmd.upd && match_reg)
        begin
            qty_reg <= req_qty;
        end
        else if (cmd.shift && (MY_IDX >= hit_idx))
        begin
            key_reg <= nb_key;
            qty_reg <= nb_qty;
        end
    end

endmodule

// ===== hw/rtl/keyed_table_with_compaction_unit.sv =====
// ----------------------------------------------------------------------------
// keyed_table_with_compaction_unit: packed key/quantity table
// Insert, update, remove with compaction and read by position over a row of
// cells, one per entry.
// ----------------------------------------------------------------------------
//  channel | signals                                   | beat
//  --------+-------------------------------------------+---------------------
//  in      | in_valid/in_ready, req_type, key,         | one request
//          | quantity, position                        |
//  out     | out_valid/out_ready, status, entry_count, | one result
//          | key_out, quantity_out                     |
//
// A request passes through accept, key compare in every cell, OR-reduce of
// the match/read lines, then apply and load the output register.
// The apply step waits while a previous result is still held on out.
// A new request is taken while a result waits on out.
// Reset clears the fill count and control; cell contents are never cleared.
// ----------------------------------------------------------------------------
module keyed_table_with_compaction_unit #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] key,
    input  logic signed [31:0] quantity,
    input  logic [5:0]         position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic [6:0]         entry_count,
    output logic signed [31:0] key_out,
    output logic [30:0]        quantity_out
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int P_W   = (IDX_W > 6) ? IDX_W : 6;
    localparam int C_W   = (CNT_W > 6) ? CNT_W : 6;
    localparam int EXT_W = CNT_W + 7;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    kt_pkg::state_t state_reg, state_next;

    logic [1:0]          req_reg;
    logic [31:0]         rkey_reg;
    logic [31:0]         rqty_reg;
    logic [5:0]          pos_reg;
    logic [CNT_W-1:0]    count_reg;

    logic                found_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [31:0]         rd_key_reg;
    logic [30:0]         rd_qty_reg;

    logic [31:0]         cell_key [CAPACITY];
    logic [30:0]         cell_qty [CAPACITY];
    logic [CAPACITY-1:0] match_vec;

    logic                found_c;
    logic [IDX_W-1:0]    idx_c;
    logic [31:0]         rd_key_c;
    logic [30:0]         rd_qty_c;

    kt_pkg::cell_cmd_t   cmd;
    kt_pkg::status_t     st_c;
    logic                out_free;
    logic                do_ins, do_upd, do_rem, rd_ok;
    logic                qneg;
    logic [EXT_W-1:0]    count_ext;

    assign in_ready = (state_reg == kt_pkg::S_IDLE);
    assign out_free = !out_valid || out_ready;
    assign qneg     = rqty_reg[31];

    // ---------------- cell row ----------------
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [31:0] nb_key;
        logic [30:0] nb_qty;

        if (g < CAPACITY - 1)
        begin : g_nb
            assign nb_key = cell_key[g+1];
            assign nb_qty = cell_qty[g+1];
        end
        else
        begin : g_last
            assign nb_key = cell_key[g];
            assign nb_qty = cell_qty[g];
        end

        kt_cell #(
            .CELL_IDX (g),
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .req_key   (rkey_reg),
            .req_qty   (rqty_reg[30:0]),
            .count     (count_reg),
            .hit_idx   (idx_reg),
            .nb_key    (nb_key),
            .nb_qty    (nb_qty),
            .key_reg   (cell_key[g]),
            .qty_reg   (cell_qty[g]),
            .match_reg (match_vec[g])
        );
    end

    // keys are unique inside the table, so at most one cell matches and the
    // index can be OR-encoded
    always_comb
    begin
        found_c  = 1'b0;
        idx_c    = '0;
        rd_key_c = '0;
        rd_qty_c = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match_vec[i])
            begin
                found_c = 1'b1;
                idx_c   = idx_c | IDX_W'(i);
            end
            if (P_W'(i) == P_W'(pos_reg))
            begin
                rd_key_c = rd_key_c | cell_key[i];
                rd_qty_c = rd_qty_c | cell_qty[i];
            end
        end
    end

    // ---------------- decision ----------------
    always_comb
    begin
        st_c   = kt_pkg::ST_OK;
        do_ins = 1'b0;
        do_upd = 1'b0;
        do_rem = 1'b0;
        rd_ok  = 1'b0;
        case (kt_pkg::req_t'(req_reg))
            kt_pkg::REQ_INSERT:
            begin
                if (count_reg >= FULL_CNT)  st_c = kt_pkg::ST_FULL;
                else if (found_reg)         st_c = kt_pkg::ST_DUP;
                else if (qneg)              st_c = kt_pkg::ST_NEGQ;
                else                        do_ins = 1'b1;
            end
            kt_pkg::REQ_UPDATE:
            begin
                if (count_reg == '0)        st_c = kt_pkg::ST_EMPTY;
                else if (!found_reg)        st_c = kt_pkg::ST_NOTFOUND;
                else if (qneg)              st_c = kt_pkg::ST_NEGQ;
                else                        do_upd = 1'b1;
            end
            kt_pkg::REQ_REMOVE:
            begin
                if (count_reg == '0)        st_c = kt_pkg::ST_EMPTY;
                else if (!found_reg)        st_c = kt_pkg::ST_NOTFOUND;
                else                        do_rem = 1'b1;
            end
            kt_pkg::REQ_READ:
            begin
                if (C_W'(pos_reg) >= C_W'(count_reg)) st_c = kt_pkg::ST_BADPOS;
                else                                  rd_ok = 1'b1;
            end
            default:
            begin
                st_c = kt_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.compare = (state_reg == kt_pkg::S_MATCH);
        if ((state_reg == kt_pkg::S_APPLY) && out_free)
        begin
            cmd.ins   = do_ins;
            cmd.upd   = do_upd;
            cmd.shift = do_rem;
        end
    end

    // ---------------- control ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kt_pkg::S_IDLE:   if (in_valid) state_next = kt_pkg::S_MATCH;
            kt_pkg::S_MATCH:  state_next = kt_pkg::S_REDUCE;
            kt_pkg::S_REDUCE: state_next = kt_pkg::S_APPLY;
            kt_pkg::S_APPLY:  if (out_free) state_next = kt_pkg::S_IDLE;
            default:          state_next = kt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kt_pkg::S_IDLE;
            count_reg <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == kt_pkg::S_APPLY) && out_free)
            begin
                out_valid <= 1'b1;
                if (do_ins)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else if (do_rem)
                begin
                    count_reg <= count_reg - CNT_W'(1);
                end
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg  <= req_type;
            rkey_reg <= key;
            rqty_reg <= quantity;
            pos_reg  <= position;
        end
        if (state_reg == kt_pkg::S_REDUCE)
        begin
            found_reg  <= found_c;
            idx_reg    <= idx_c;
            rd_key_reg <= rd_key_c;
            rd_qty_reg <= rd_qty_c;
        end
    end

    always_comb
    begin
        count_ext = EXT_W'(count_reg);
        if (do_ins)
        begin
            count_ext = EXT_W'(count_reg) + EXT_W'(1);
        end
        else if (do_rem)
        begin
            count_ext = EXT_W'(count_reg) - EXT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == kt_pkg::S_APPLY) && out_free)
        begin
            status       <= st_c;
            entry_count  <= count_ext[6:0];
            key_out      <= rd_ok ? rd_key_reg : '0;
            quantity_out <= rd_ok ? rd_qty_reg : '0;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("fill count above capacity");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kt_pkg::S_REDUCE) |-> $onehot0(match_vec))
        else $error("more than one cell holds the key");

    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == kt_pkg::S_MATCH))
        else $error("accepted request did not start a compare");

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != kt_pkg::ST_OK)) |-> (key_out == '0 && quantity_out == '0))
        else $error("failed request carries entry data");
`endif

endmodule

// ===== tb/kt_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kt_table_checker: result predictor and scoreboard for the keyed table
// Watches both channels, keeps its own copy of the key/quantity table,
// queues the expected result of every request beat and compares each
// result beat field by field against the oldest one.
// ----------------------------------------------------------------------------
module kt_table_checker
    import kt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] key,
    input  logic signed [31:0] quantity,
    input  logic [5:0]         position,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [2:0]         status,
    input  logic [6:0]         entry_count,
    input  logic signed [31:0] key_out,
    input  logic [30:0]        quantity_out,
    output int                 mismatches,
    output int                 pending
);

    typedef struct packed {
        status_t            status;
        logic [6:0]         count;
        logic [KEY_W-1:0]   key;
        logic [QTY_W-1:0]   qty;
    } table_result_t;

    logic [KEY_W-1:0] model_keys [CAPACITY];
    logic [QTY_W-1:0] model_qtys [CAPACITY];
    int               model_fill;
    table_result_t    expected_results [$];

    // linear search from position 0, -1 when absent
    function automatic int find_key(logic [KEY_W-1:0] k);
        for (int i = 0; i < model_fill; i++)
            if (model_keys[i] == k)
                return i;
        return -1;
    endfunction

    function automatic table_result_t apply_request(req_t r, logic [31:0] k,
                                                    logic [31:0] q, logic [5:0] p);
        table_result_t res;
        int            idx;
        res = '{status: ST_OK, count: '0, key: '0, qty: '0};
        case (r)
            REQ_INSERT:
                if (model_fill >= CAPACITY)
                    res.status = ST_FULL;
                else if (find_key(k) >= 0)
                    res.status = ST_DUP;
                else if (q[31])
                    res.status = ST_NEGQ;
                else
                begin
                    model_keys[model_fill] = k;
                    model_qtys[model_fill] = q[30:0];
                    model_fill++;
                end
            REQ_UPDATE:
            begin
                idx = find_key(k);
                if (model_fill == 0)
                    res.status = ST_EMPTY;
                else if (idx < 0)
                    res.status = ST_NOTFOUND;
                else if (q[31])
                    res.status = ST_NEGQ;
                else
                    model_qtys[idx] = q[30:0];
            end
            REQ_REMOVE:
            begin
                idx = find_key(k);
                if (model_fill == 0)
                    res.status = ST_EMPTY;
                else if (idx < 0)
                    res.status = ST_NOTFOUND;
                else
                begin
                    // close the gap
                    for (int i = idx; i + 1 < model_fill; i++)
                    begin
                        model_keys[i] = model_keys[i + 1];
                        model_qtys[i] = model_qtys[i + 1];
                    end
                    model_fill--;
                end
            end
            default:
                if (int'(p) >= model_fill || int'(p) >= CAPACITY)
                    res.status = ST_BADPOS;
                else
                begin
                    res.key = model_keys[p];
                    res.qty = model_qtys[p];
                end
        endcase
        res.count = model_fill[6:0];
        return res;
    endfunction

    initial
    begin
        mismatches = 0;
        pending    = 0;
        model_fill = 0;
    end

    always @(posedge clk)
    begin
        table_result_t exp_res;
        if (rst_n)
        begin
            // result side first: a request accepted this edge cannot be the one leaving
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (status !== exp_res.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_res.status, status);
                        mismatches++;
                    end
                    if (entry_count !== exp_res.count)
                    begin
                        $error("entry_count: expected %0d, got %0d", exp_res.count,
                               entry_count);
                        mismatches++;
                    end
                    if (key_out !== exp_res.key)
                    begin
                        $error("key_out: expected %h, got %h", exp_res.key, key_out);
                        mismatches++;
                    end
                    if (quantity_out !== exp_res.qty)
                    begin
                        $error("quantity_out: expected %h, got %h", exp_res.qty,
                               quantity_out);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(apply_request(req_t'(req_type), key,
                                                         quantity, position));
            pending = expected_results.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression for keyed_table_with_compaction_unit
// Directed requests over empty/duplicate/missing-key/negative-quantity
// and out-of-range reads, then phased random traffic that fills, churns and
// drains the table with random idling on both channels and one long stall.
// ----------------------------------------------------------------------------
module tb;
    import kt_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int NUM_RANDOM  = 550;
    localparam int POOL_SIZE   = 80;
    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_STALL  = 400;

    localparam int MIX_FILL     = 0;
    localparam int MIX_BALANCED = 1;
    localparam int MIX_DRAIN    = 2;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         req_type;
    logic signed [31:0] key;
    logic signed [31:0] quantity;
    logic [5:0]         position;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         status;
    logic [6:0]         entry_count;
    logic signed [31:0] key_out;
    logic [30:0]        quantity_out;

    int                 mismatches;
    int                 pending;
    int                 cycles;
    bit                 tx_idle_on;
    bit                 rx_idle_on;
    bit                 stall_request;
    logic [31:0]        key_pool [POOL_SIZE];

    keyed_table_with_compaction_unit #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .key         (key),
        .quantity    (quantity),
        .position    (position),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .entry_count (entry_count),
        .key_out     (key_out),
        .quantity_out(quantity_out)
    );

    kt_table_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .key         (key),
        .quantity    (quantity),
        .position    (position),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .entry_count (entry_count),
        .key_out     (key_out),
        .quantity_out(quantity_out),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    initial
        clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("keyed_table_with_compaction_unit regression: fail");
            $finish;
        end
    end

    // returns at the edge where the request beat is taken
    task automatic send_request(req_t r, logic [31:0] k, logic [31:0] q, logic [5:0] p);
        bit taken;
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= r;
        key      <= k;
        quantity <= q;
        position <= p;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic send_random(int mix);
        req_t        r;
        logic [31:0] k;
        logic [31:0] q;
        logic [5:0]  p;
        int          roll;
        int          qroll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
                r = roll < 75 ? REQ_INSERT : roll < 85 ? REQ_READ :
                    roll < 93 ? REQ_UPDATE : REQ_REMOVE;
            MIX_DRAIN:
                r = roll < 15 ? REQ_INSERT : roll < 35 ? REQ_READ :
                    roll < 45 ? REQ_UPDATE : REQ_REMOVE;
            default:
                r = roll < 30 ? REQ_INSERT : roll < 55 ? REQ_READ :
                    roll < 80 ? REQ_UPDATE : REQ_REMOVE;
        endcase
        k = ($urandom_range(0, 4) == 0) ? $urandom : key_pool[$urandom_range(0, POOL_SIZE - 1)];
        qroll = $urandom_range(0, 19);
        q = $urandom;
        if (qroll == 0)
            q = 32'h0;
        else if (qroll == 1)
            q = 32'h7fff_ffff;
        else if (qroll < 4)
            q[31] = 1'b1;
        else
            q[31] = 1'b0;
        p = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 63);
        send_request(r, k, q, p);
    endtask

    // result side: random back-pressure bursts plus one long hold-off
    initial
    begin
        bit stall_done;
        stall_done = 1'b0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_request && !stall_done)
            begin
                out_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
                stall_done = 1'b1;
                out_ready <= 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        int mix;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        req_type      = REQ_INSERT;
        key           = '0;
        quantity      = '0;
        position      = '0;
        cycles        = 0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        stall_request = 1'b0;

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table
        send_request(REQ_READ,   $urandom, $urandom, 6'd0);
        send_request(REQ_READ,   $urandom, $urandom, 6'd63);
        send_request(REQ_UPDATE, 32'h0, 32'd7, 6'd0);
        send_request(REQ_REMOVE, 32'h0, 32'd0, 6'd0);
        // inserts at the key and quantity extremes, duplicate before negative
        send_request(REQ_INSERT, 32'h8000_0000, 32'h0, 6'd0);
        send_request(REQ_INSERT, 32'h7fff_ffff, 32'h7fff_ffff, 6'd63);
        send_request(REQ_INSERT, 32'h8000_0000, 32'd5, 6'd0);
        send_request(REQ_INSERT, 32'h8000_0000, 32'h8000_0000, 6'd0);
        send_request(REQ_INSERT, 32'h0, 32'h8000_0000, 6'd0);
        send_request(REQ_INSERT, 32'hffff_ffff, 32'hffff_ffff, 6'd0);
        send_request(REQ_INSERT, 32'hffff_ffff, 32'd123, 6'd0);
        // update: missing key wins over negative quantity
        send_request(REQ_UPDATE, 32'h1234_5678, 32'd1, 6'd0);
        send_request(REQ_UPDATE, 32'h1234_5678, 32'hffff_ffff, 6'd0);
        send_request(REQ_UPDATE, 32'h7fff_ffff, 32'hffff_ffff, 6'd0);
        send_request(REQ_UPDATE, 32'h7fff_ffff, 32'd42, 6'd0);
        for (int i = 0; i < 4; i++)
            send_request(REQ_READ, $urandom, $urandom, 6'(i));
        // remove the head so the rest shifts down
        send_request(REQ_REMOVE, 32'h8000_0000, $urandom, 6'd0);
        send_request(REQ_READ, $urandom, $urandom, 6'd0);
        send_request(REQ_READ, $urandom, $urandom, 6'd1);
        send_request(REQ_REMOVE, 32'h0, $urandom, 6'd0);
        send_request(REQ_REMOVE, 32'hffff_ffff, $urandom, 6'd0);
        send_request(REQ_READ, $urandom, $urandom, 6'd0);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n < 150)
                mix = MIX_FILL;
            else if (n < 300)
                mix = MIX_BALANCED;
            else if (n < 400)
                mix = MIX_DRAIN;
            else if (n < 480)
                mix = MIX_FILL;
            else
                mix = MIX_BALANCED;
            tx_idle_on = !((n >= 150 && n < 250) || n >= 450);
            rx_idle_on = tx_idle_on;
            if (n == 100)
                stall_request = 1'b1;
            if (n == 300)
            begin
                // sender holds until the table has answered everything
                in_valid <= 1'b0;
                do
                    @(negedge clk);
                while (pending != 0);
                @(posedge clk);
            end
            send_random(mix);
        end
        in_valid <= 1'b0;

        do
            @(negedge clk);
        while (pending != 0);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("keyed_table_with_compaction_unit regression: pass");
        else
            $display("keyed_table_with_compaction_unit regression: fail");
        $finish;
    end

endmodule
